>>> rtl/epc_pkg.sv
// Package for the epoch seconds to calendar converter: widths, constants, state type.
package epc_pkg;

  // Input bits taken into account
  localparam int SECONDS_WIDTH = 32;

  // Field widths
  localparam int YEAR_W = 12;
  localparam int DOY_W  = 9;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;

  // One day is more than 2^16 seconds, so the day count needs 16 fewer bits
  localparam int DAY_W  = SECONDS_WIDTH - 16;
  // Seconds of the day fit in 17 bits
  localparam int SOD_W  = 17;
  localparam int CNT_W  = $clog2(SECONDS_WIDTH);

  localparam logic [SOD_W:0]   SECS_PER_DAY  = (SOD_W + 1)'(86400);
  localparam logic [SOD_W-1:0] SECS_PER_HOUR = SOD_W'(3600);
  localparam logic [SOD_W-1:0] SECS_PER_MIN  = SOD_W'(60);

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(1970);
  // Epoch year modulo 4, 100 and 400
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  localparam logic [DAY_W-1:0] DAYS_COMMON = DAY_W'(365);
  localparam logic [DAY_W-1:0] DAYS_LEAP   = DAY_W'(366);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAYS,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_DONE
  } state_e;

endpackage

>>> rtl/epoch_seconds_to_calendar.sv
// Epoch seconds to year, day of year, hour, minute and second.
//
// Input channel: in_valid_i / in_stall_o with epoch_seconds_i. A transfer
// happens when in_valid_i is high and in_stall_o is low. Only one item is in
// work at a time; in_stall_o is high from the accepting edge until the result
// has moved into the output register.
// Output channel: out_valid_o / out_stall_i with year_o, day_of_year_o,
// hour_o, minute_o, second_o. The result register holds while out_stall_i is
// high; a new item may be accepted and worked on meanwhile, and it waits in
// its last step until the register is free.
// Steps per item: bit-serial division by 86400 for the day count and
// seconds of day, then the hour and the minute digit (shift and subtract),
// then the year loop from 1970, and a last step that loads the result.
// The next transfer can be taken in the idle state that follows the load.
// The year loop subtracts one year length per cycle, so late years take
// the longest.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// out_valid_o; nothing else needs clearing.
module epoch_seconds_to_calendar
  import epc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [SECONDS_WIDTH-1:0] epoch_seconds_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [YEAR_W-1:0]        year_o,
  output logic [DOY_W-1:0]         day_of_year_o,
  output logic [HOUR_W-1:0]        hour_o,
  output logic [MIN_W-1:0]         minute_o,
  output logic [SEC_W-1:0]         second_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [SECONDS_WIDTH-1:0] quo_q, quo_d;    // dividend in, quotient (days) out
  logic [SOD_W-1:0]         rem_q, rem_d;    // seconds of day, then leftovers
  logic [HOUR_W-1:0]        hour_q, hour_d;
  logic [MIN_W-1:0]         min_q, min_d;
  logic [YEAR_W-1:0]        year_q, year_d;
  logic [1:0]               m4_q, m4_d;
  logic [6:0]               m100_q, m100_d;
  logic [8:0]               m400_q, m400_d;

  logic                     out_valid_q, out_valid_d;
  logic [YEAR_W-1:0]        out_year_q;
  logic [DOY_W-1:0]         out_doy_q;
  logic [HOUR_W-1:0]        out_hour_q;
  logic [MIN_W-1:0]         out_min_q;
  logic [SEC_W-1:0]         out_sec_q;

  logic [SOD_W:0]           trial;
  logic                     trial_ge;
  logic [SOD_W-1:0]         digit_div;
  logic                     digit_ge;
  logic [DAY_W-1:0]         days;
  logic                     leap;
  logic [DAY_W-1:0]         year_len;
  logic [DAY_W-1:0]         doy_sum;
  logic                     out_free;
  logic                     out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Restoring division step by 86400
  assign trial    = {rem_q, quo_q[SECONDS_WIDTH-1]};
  assign trial_ge = (trial >= SECS_PER_DAY);

  // Hour and minute digits: compare against the divisor shifted by the digit position
  always_comb begin
    if (state_q == S_HOUR) begin
      digit_div = SECS_PER_HOUR << cnt_q[2:0];
    end else begin
      digit_div = SECS_PER_MIN << cnt_q[2:0];
    end
  end
  assign digit_ge = (rem_q >= digit_div);

  // Gregorian leap rule from running year residues
  assign days     = quo_q[DAY_W-1:0];
  assign leap     = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);
  assign year_len = leap ? DAYS_LEAP : DAYS_COMMON;
  assign doy_sum  = days + DAY_W'(1);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    hour_q <= hour_d;
    min_q  <= min_d;
    year_q <= year_d;
    m4_q   <= m4_d;
    m100_q <= m100_d;
    m400_q <= m400_d;
    if (out_load) begin
      out_year_q <= year_q;
      out_doy_q  <= doy_sum[DOY_W-1:0];
      out_hour_q <= hour_q;
      out_min_q  <= min_q;
      out_sec_q  <= rem_q[SEC_W-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    hour_d   = hour_q;
    min_d    = min_q;
    year_d   = year_q;
    m4_d     = m4_q;
    m100_d   = m100_q;
    m400_d   = m400_q;
    out_load = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          quo_d   = epoch_seconds_i;
          rem_d   = '0;
          cnt_d   = '0;
          year_d  = EPOCH_YEAR;
          m4_d    = EPOCH_MOD4;
          m100_d  = EPOCH_MOD100;
          m400_d  = EPOCH_MOD400;
          state_d = S_DAYS;
        end
      end
      S_DAYS: begin
        // one quotient bit per cycle
        rem_d = trial_ge ? SOD_W'(trial - SECS_PER_DAY) : trial[SOD_W-1:0];
        quo_d = {quo_q[SECONDS_WIDTH-2:0], trial_ge};
        if (cnt_q == CNT_W'(SECONDS_WIDTH - 1)) begin
          cnt_d   = CNT_W'(HOUR_W - 1);
          state_d = S_HOUR;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_HOUR: begin
        if (digit_ge) begin
          rem_d = rem_q - digit_div;
        end
        hour_d = {hour_q[HOUR_W-2:0], digit_ge};
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(MIN_W - 1);
          state_d = S_MIN;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_MIN: begin
        // what is left afterwards is the second
        if (digit_ge) begin
          rem_d = rem_q - digit_div;
        end
        min_d = {min_q[MIN_W-2:0], digit_ge};
        if (cnt_q == '0) begin
          state_d = S_YEAR;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_YEAR: begin
        // take away one year length per cycle
        if (days < year_len) begin
          state_d = S_DONE;
        end else begin
          quo_d  = {{(SECONDS_WIDTH - DAY_W){1'b0}}, days - year_len};
          year_d = year_q + YEAR_W'(1);
          m4_d   = m4_q + 2'd1;
          m100_d = (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
          m400_d = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  assign out_valid_o   = out_valid_q;
  assign year_o        = out_year_q;
  assign day_of_year_o = out_doy_q;
  assign hour_o        = out_hour_q;
  assign minute_o      = out_min_q;
  assign second_o      = out_sec_q;

`ifndef NO_ASSERTIONS
  // An input transfer starts the day division
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DAYS))
    else $error("input transfer did not start the division");

  // Residues modulo 4 and 100 agree while counting years
  a_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_YEAR) |-> (m100_q[1:0] == m4_q))
    else $error("leap residues out of step");

  // A finished item reaches the output once the register is free
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> (out_valid_o && state_q == S_IDLE))
    else $error("finished result not loaded");

  // Delivered time of day is in range and the day of year is not zero
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o < HOUR_W'(24) && minute_o < MIN_W'(60) &&
                     second_o < SEC_W'(60) && day_of_year_o != '0))
    else $error("result field out of range");
`endif

endmodule

>>> tb/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// Testbench for epoch_seconds_to_calendar: directed and random timestamps checked against a calendar model.
module tb_epoch_seconds_to_calendar
  import epc_pkg::*;
();

  localparam int unsigned DAY_SECS   = 86400;
  localparam int unsigned HOUR_SECS  = 3600;
  localparam int unsigned MIN_SECS   = 60;
  localparam int unsigned FIRST_YEAR = 1970;
  localparam int unsigned LAST_YEAR  = 2106;

  localparam int RANDOM_ITEMS   = 1230;
  localparam int CALM_ITEMS     = 150;
  // Covers the slowest item together with a longest output stall and input gap
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 250;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } cal_t;

  // Directed stimulus; known rows carry a hand-written date, others use the model
  typedef struct packed {
    logic [SECONDS_WIDTH-1:0] secs;
    logic                     known;
    cal_t                     want;
  } row_t;

  localparam int N_ROWS = 21;
  localparam row_t DIRECTED_ROWS [N_ROWS] = '{
    '{32'd0,          1'b1, '{12'd1970, 9'd1,   5'd0,  6'd0,  6'd0}},
    '{32'd59,         1'b1, '{12'd1970, 9'd1,   5'd0,  6'd0,  6'd59}},
    '{32'd60,         1'b1, '{12'd1970, 9'd1,   5'd0,  6'd1,  6'd0}},
    '{32'd3599,       1'b1, '{12'd1970, 9'd1,   5'd0,  6'd59, 6'd59}},
    '{32'd3600,       1'b1, '{12'd1970, 9'd1,   5'd1,  6'd0,  6'd0}},
    '{32'd86399,      1'b1, '{12'd1970, 9'd1,   5'd23, 6'd59, 6'd59}},
    '{32'd86400,      1'b1, '{12'd1970, 9'd2,   5'd0,  6'd0,  6'd0}},
    // last day of a common year, then the first of the next
    '{32'd31449600,   1'b1, '{12'd1970, 9'd365, 5'd0,  6'd0,  6'd0}},
    '{32'd31535999,   1'b1, '{12'd1970, 9'd365, 5'd23, 6'd59, 6'd59}},
    '{32'd31536000,   1'b1, '{12'd1971, 9'd1,   5'd0,  6'd0,  6'd0}},
    // leap day 366 of 1972
    '{32'd94608000,   1'b1, '{12'd1972, 9'd366, 5'd0,  6'd0,  6'd0}},
    '{32'd94694400,   1'b1, '{12'd1973, 9'd1,   5'd0,  6'd0,  6'd0}},
    // century years: 2000 is leap, 2100 is not
    '{32'd978220800,  1'b0, '0},
    '{32'd4102444799, 1'b0, '0},
    '{32'd4133894400, 1'b0, '0},
    '{32'd4133980799, 1'b0, '0},
    '{32'd4133980800, 1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},
    '{32'h8000_0000,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 9'd38,  5'd6,  6'd28, 6'd15}}
  };

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic [SECONDS_WIDTH-1:0] epoch_seconds_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic [YEAR_W-1:0]        year_o;
  logic [DOY_W-1:0]         day_of_year_o;
  logic [HOUR_W-1:0]        hour_o;
  logic [MIN_W-1:0]         minute_o;
  logic [SEC_W-1:0]         second_o;

  cal_t        expected_dates [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  bit          calm         = 1'b0;

  epoch_seconds_to_calendar dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .epoch_seconds_i(epoch_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .year_o         (year_o),
    .day_of_year_o  (day_of_year_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  // Calendar date of a timestamp: split into days and seconds of day, walk the years
  function automatic cal_t to_calendar(input logic [SECONDS_WIDTH-1:0] secs);
    longint unsigned days;
    longint unsigned sod;
    int unsigned     y;
    cal_t            date;
    days = secs / DAY_SECS;
    sod  = secs % DAY_SECS;
    y    = FIRST_YEAR;
    while (days >= (leap_year(y) ? 366 : 365)) begin
      days -= leap_year(y) ? 366 : 365;
      y++;
    end
    date.year   = YEAR_W'(y);
    date.doy    = DOY_W'(days + 1);
    date.hour   = HOUR_W'(sod / HOUR_SECS);
    date.minute = MIN_W'((sod % HOUR_SECS) / MIN_SECS);
    date.second = SEC_W'(sod % MIN_SECS);
    return date;
  endfunction

  // One input transfer, then maybe a random gap
  task automatic convert(input logic [SECONDS_WIDTH-1:0] secs, input cal_t want);
    epoch_seconds_i <= secs;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_dates.push_back(want);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every pending date has come back
  task automatic drain_pending();
    in_valid_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
  endtask

  // Result side: check each transfer, stall in random bursts
  always @(posedge clk_i) begin : take_result
    cal_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          $error("unexpected result: year %0d day %0d", year_o, day_of_year_o);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          if (year_o !== want.year) begin
            $error("year: expected %0d, got %0d", want.year, year_o);
            mismatches++;
          end
          if (day_of_year_o !== want.doy) begin
            $error("day_of_year: expected %0d, got %0d", want.doy, day_of_year_o);
            mismatches++;
          end
          if (hour_o !== want.hour) begin
            $error("hour: expected %0d, got %0d", want.hour, hour_o);
            mismatches++;
          end
          if (minute_o !== want.minute) begin
            $error("minute: expected %0d, got %0d", want.minute, minute_o);
            mismatches++;
          end
          if (second_o !== want.second) begin
            $error("second: expected %0d, got %0d", want.second, second_o);
            mismatches++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned base;
    int unsigned     y;
    logic [SECONDS_WIDTH-1:0] secs;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIRECTED_ROWS[i]) begin
      convert(DIRECTED_ROWS[i].secs, DIRECTED_ROWS[i].known ?
              DIRECTED_ROWS[i].want : to_calendar(DIRECTED_ROWS[i].secs));
    end
    drain_pending();

    // Random timestamps, weighted toward year and hour boundaries
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_pending();
      calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
      case ($urandom_range(0, 3))
        0: begin
          // within a day either side of New Year
          y = $urandom_range(FIRST_YEAR + 1, LAST_YEAR);
          base = 0;
          for (int unsigned k = FIRST_YEAR; k < y; k++) base += leap_year(k) ? 366 : 365;
          base = base * DAY_SECS + $urandom_range(0, 2 * DAY_SECS) - DAY_SECS;
        end
        1: begin
          // a few seconds either side of an hour boundary
          base = 64'($urandom / HOUR_SECS) * HOUR_SECS;
          if ($urandom_range(0, 1) == 0) begin
            base += $urandom_range(0, 2);
          end else begin
            base += HOUR_SECS - 1 - $urandom_range(0, 2);
          end
        end
        default: base = $urandom;
      endcase
      secs = (base > 64'hFFFF_FFFF) ? SECONDS_WIDTH'($urandom) : SECONDS_WIDTH'(base);
      convert(secs, to_calendar(secs));
    end

    in_valid_i <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
